[rtl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg: shared widths and types for the 3D segment distance pipeline
// Fixed-point formats, datapath widths and stage latencies used by the
// top level, the wide multiplier, the divider and the checker.
// ----------------------------------------------------------------------------
package ssd_pkg;

    // Coordinate format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Coordinate difference, component product, dot product
    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW;
    localparam int DOTW = PW + 2;

    // Wide multiplier operand, limb and product
    localparam int MW  = DOTW;
    localparam int LW  = MW / 2;
    localparam int MPW = 2 * MW;

    // Degree-four quantities (signed) and divider operands
    localparam int QW = MPW + 2;

    // Threshold register
    localparam int EW = 63;
    localparam logic [EW-1:0] EPS_RESET = EW'(4096);

    // Segment parameters: unsigned Q1.PB
    localparam int PB  = 32;
    localparam int SCW = PB + 1;

    // Square root input and output distance
    localparam int SQW   = MPW;
    localparam int SQS   = SQW / 2;
    localparam int DISTW = COORD_WIDTH + 3;

    // Scaled constant one at Q.(4*FRAC_BITS)
    localparam logic [QW-1:0] ONE_Q = QW'(1) << (4 * FRAC_BITS);

    // Stage latencies
    localparam int MUL_LAT = 4;
    localparam int DIV_LAT = PB + 2;
    localparam int LAT     = 3 + MUL_LAT + 3 + DIV_LAT + 2 + MUL_LAT + 1 + SQS + 1;

    // Divider control that travels with each item
    typedef struct packed {
        logic vld;
        logic zero;
        logic full;
    } t_div_ctl;

endpackage

[rtl/segment_segment_distance_3d.sv]
// ----------------------------------------------------------------------------
// segment_segment_distance_3d: closest distance between two 3D segments
// Clamped closest-parameter method on exact integers, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock: start is accepted at every edge (busy is
// never raised) and each result comes out as a one-cycle o_done strobe with
// o_distance; the receiver cannot hold it. The latency is mostly set by the
// 34-stage parameter divider and the 68-step square root. Write the epsilon
// register only while no pair is in flight.
module segment_segment_distance_3d (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [ssd_pkg::COORD_WIDTH-1:0] i_first_start_x,
    input  logic signed [ssd_pkg::COORD_WIDTH-1:0] i_first_start_y,
    input  logic signed [ssd_pkg::COORD_WIDTH-1:0] i_first_start_z,
    input  logic signed [ssd_pkg::COORD_WIDTH-1:0] i_first_end_x,
    input  logic signed [ssd_pkg::COORD_WIDTH-1:0] i_first_end_y,
    input  logic signed [ssd_pkg::COORD_WIDTH-1:0] i_first_end_z,
    input  logic signed [ssd_pkg::COORD_WIDTH-1:0] i_second_start_x,
    input  logic signed [ssd_pkg::COORD_WIDTH-1:0] i_second_start_y,
    input  logic signed [ssd_pkg::COORD_WIDTH-1:0] i_second_start_z,
    input  logic signed [ssd_pkg::COORD_WIDTH-1:0] i_second_end_x,
    input  logic signed [ssd_pkg::COORD_WIDTH-1:0] i_second_end_y,
    input  logic signed [ssd_pkg::COORD_WIDTH-1:0] i_second_end_z,
    input  logic                                 i_cfg_we,
    input  logic [ssd_pkg::EW-1:0]               i_cfg_wdata,
    output logic                                 o_done,
    output logic [ssd_pkg::DISTW-1:0]            o_distance
);
    localparam int CW      = ssd_pkg::COORD_WIDTH;
    localparam int DW      = ssd_pkg::DW;
    localparam int PW      = ssd_pkg::PW;
    localparam int DOTW    = ssd_pkg::DOTW;
    localparam int MW      = ssd_pkg::MW;
    localparam int MPW     = ssd_pkg::MPW;
    localparam int QW      = ssd_pkg::QW;
    localparam int PB      = ssd_pkg::PB;
    localparam int SCW     = ssd_pkg::SCW;
    localparam int SQW     = ssd_pkg::SQW;
    localparam int SQS     = ssd_pkg::SQS;
    localparam int DISTW   = ssd_pkg::DISTW;
    localparam int MUL_LAT = ssd_pkg::MUL_LAT;
    localparam int DIV_LAT = ssd_pkg::DIV_LAT;
    localparam int SH2     = 2 * ssd_pkg::FRAC_BITS;
    localparam logic [SQW-1:0] HALF = SQW'(1) << (PB - 1);
    localparam logic [SQW-1:0] DMAX = (SQW'(1) << DISTW) - SQW'(1);

    // ------------------------------------------------------------------
    // Threshold register
    // ------------------------------------------------------------------
    logic [ssd_pkg::EW-1:0] r_epsilon;
    logic signed [QW-1:0]   eps_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon <= ssd_pkg::EPS_RESET;
        end else if (i_cfg_we) begin
            r_epsilon <= i_cfg_wdata;
        end
    end

    assign eps_q = QW'(r_epsilon);
    assign busy  = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: direction and offset vectors
    // ------------------------------------------------------------------
    logic signed [CW-1:0] p0 [3], p1 [3], q0 [3], q1 [3];
    logic                 r1_vld;
    logic signed [DW-1:0] r1_u [3], r1_v [3], r1_w [3];

    assign p0 = '{i_first_start_x, i_first_start_y, i_first_start_z};
    assign p1 = '{i_first_end_x, i_first_end_y, i_first_end_z};
    assign q0 = '{i_second_start_x, i_second_start_y, i_second_start_z};
    assign q1 = '{i_second_end_x, i_second_end_y, i_second_end_z};

    // ------------------------------------------------------------------
    // Stage 2: component products; stage 3: dot products
    // ------------------------------------------------------------------
    logic                 r2_vld;
    logic signed [PW-1:0] r2_uu [3], r2_uv [3], r2_vv [3], r2_uw [3], r2_vw [3];
    logic signed [DW-1:0] r2_u [3], r2_v [3], r2_w [3];

    logic                   r3_vld;
    logic signed [DOTW-1:0] r3_a, r3_b, r3_c, r3_d, r3_e;
    logic signed [DW-1:0]   r3_u [3], r3_v [3], r3_w [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_u[k]  <= DW'(p1[k]) - DW'(p0[k]);
            r1_v[k]  <= DW'(q1[k]) - DW'(q0[k]);
            r1_w[k]  <= DW'(p0[k]) - DW'(q0[k]);

            r2_uu[k] <= r1_u[k] * r1_u[k];
            r2_uv[k] <= r1_u[k] * r1_v[k];
            r2_vv[k] <= r1_v[k] * r1_v[k];
            r2_uw[k] <= r1_u[k] * r1_w[k];
            r2_vw[k] <= r1_v[k] * r1_w[k];
            r2_u[k]  <= r1_u[k];
            r2_v[k]  <= r1_v[k];
            r2_w[k]  <= r1_w[k];

            r3_u[k]  <= r2_u[k];
            r3_v[k]  <= r2_v[k];
            r3_w[k]  <= r2_w[k];
        end
        r3_a <= r2_uu[0] + r2_uu[1] + r2_uu[2];
        r3_b <= r2_uv[0] + r2_uv[1] + r2_uv[2];
        r3_c <= r2_vv[0] + r2_vv[1] + r2_vv[2];
        r3_d <= r2_uw[0] + r2_uw[1] + r2_uw[2];
        r3_e <= r2_vw[0] + r2_vw[1] + r2_vw[2];
    end

    // ------------------------------------------------------------------
    // Degree-four products, with the dot products delayed alongside
    // ------------------------------------------------------------------
    logic                  m_vld;
    logic signed [MPW-1:0] m_ac, m_bb, m_be, m_cd, m_ae, m_bd;

    ssd_mul u_mul_ac (.i_clk, .i_rst_n, .i_vld(r3_vld), .i_a(r3_a), .i_b(r3_c),
                      .o_vld(m_vld), .o_p(m_ac));
    ssd_mul u_mul_bb (.i_clk, .i_rst_n, .i_vld(r3_vld), .i_a(r3_b), .i_b(r3_b),
                      .o_vld(), .o_p(m_bb));
    ssd_mul u_mul_be (.i_clk, .i_rst_n, .i_vld(r3_vld), .i_a(r3_b), .i_b(r3_e),
                      .o_vld(), .o_p(m_be));
    ssd_mul u_mul_cd (.i_clk, .i_rst_n, .i_vld(r3_vld), .i_a(r3_c), .i_b(r3_d),
                      .o_vld(), .o_p(m_cd));
    ssd_mul u_mul_ae (.i_clk, .i_rst_n, .i_vld(r3_vld), .i_a(r3_a), .i_b(r3_e),
                      .o_vld(), .o_p(m_ae));
    ssd_mul u_mul_bd (.i_clk, .i_rst_n, .i_vld(r3_vld), .i_a(r3_b), .i_b(r3_d),
                      .o_vld(), .o_p(m_bd));

    logic signed [DOTW-1:0] r4_a [MUL_LAT], r4_b [MUL_LAT], r4_c [MUL_LAT];
    logic signed [DOTW-1:0] r4_d [MUL_LAT], r4_e [MUL_LAT];
    logic signed [DW-1:0]   r4_u [MUL_LAT][3], r4_v [MUL_LAT][3], r4_w [MUL_LAT][3];

    always_ff @(posedge i_clk) begin
        r4_a[0] <= r3_a;
        r4_b[0] <= r3_b;
        r4_c[0] <= r3_c;
        r4_d[0] <= r3_d;
        r4_e[0] <= r3_e;
        r4_u[0] <= r3_u;
        r4_v[0] <= r3_v;
        r4_w[0] <= r3_w;
        for (int i = 1; i < MUL_LAT; i++) begin
            r4_a[i] <= r4_a[i-1];
            r4_b[i] <= r4_b[i-1];
            r4_c[i] <= r4_c[i-1];
            r4_d[i] <= r4_d[i-1];
            r4_e[i] <= r4_e[i-1];
            r4_u[i] <= r4_u[i-1];
            r4_v[i] <= r4_v[i-1];
            r4_w[i] <= r4_w[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: denominator, raw numerators, scaled degree-two terms
    // ------------------------------------------------------------------
    logic                 r8_vld;
    logic signed [QW-1:0] r8_den, r8_sn, r8_tn;
    logic signed [QW-1:0] r8_as, r8_bs, r8_cs, r8_ds, r8_es;
    logic signed [DW-1:0] r8_u [3], r8_v [3], r8_w [3];

    logic signed [QW-1:0] ext_a, ext_b, ext_c, ext_d, ext_e;

    assign ext_a = r4_a[MUL_LAT-1];
    assign ext_b = r4_b[MUL_LAT-1];
    assign ext_c = r4_c[MUL_LAT-1];
    assign ext_d = r4_d[MUL_LAT-1];
    assign ext_e = r4_e[MUL_LAT-1];

    always_ff @(posedge i_clk) begin
        r8_den <= QW'(m_ac) - QW'(m_bb);
        r8_sn  <= QW'(m_be) - QW'(m_cd);
        r8_tn  <= QW'(m_ae) - QW'(m_bd);
        r8_as  <= ext_a <<< SH2;
        r8_bs  <= ext_b <<< SH2;
        r8_cs  <= ext_c <<< SH2;
        r8_ds  <= ext_d <<< SH2;
        r8_es  <= ext_e <<< SH2;
        r8_u   <= r4_u[MUL_LAT-1];
        r8_v   <= r4_v[MUL_LAT-1];
        r8_w   <= r4_w[MUL_LAT-1];
    end

    // ------------------------------------------------------------------
    // Stage 9: parallel test and clamp of the first parameter
    // ------------------------------------------------------------------
    logic                 r9_vld;
    logic signed [QW-1:0] r9_sn, r9_sd, r9_tn, r9_td, r9_as, r9_bs, r9_ds;
    logic signed [DW-1:0] r9_u [3], r9_v [3], r9_w [3];
    logic signed [QW-1:0] n9_sn, n9_sd, n9_tn, n9_td;

    always_comb begin
        if (r8_den < eps_q) begin
            n9_sn = '0;
            n9_sd = ssd_pkg::ONE_Q;
            n9_tn = r8_es;
            n9_td = r8_cs;
        end else begin
            n9_sn = r8_sn;
            n9_sd = r8_den;
            n9_tn = r8_tn;
            n9_td = r8_den;
            if (r8_sn < 0) begin
                n9_sn = '0;
                n9_tn = r8_es;
                n9_td = r8_cs;
            end else if (r8_sn > r8_den) begin
                n9_sn = r8_den;
                n9_tn = r8_es + r8_bs;
                n9_td = r8_cs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r9_sn <= n9_sn;
        r9_sd <= n9_sd;
        r9_tn <= n9_tn;
        r9_td <= n9_td;
        r9_as <= r8_as;
        r9_bs <= r8_bs;
        r9_ds <= r8_ds;
        r9_u  <= r8_u;
        r9_v  <= r8_v;
        r9_w  <= r8_w;
    end

    // ------------------------------------------------------------------
    // Stage 10: clamp of the second parameter, first one recomputed
    // ------------------------------------------------------------------
    logic                 r10_vld;
    logic signed [QW-1:0] r10_sn, r10_sd, r10_tn, r10_td;
    logic signed [DW-1:0] r10_u [3], r10_v [3], r10_w [3];
    logic signed [QW-1:0] n10_sn, n10_sd, n10_tn, n10_x;
    logic                 n10_clamp;

    always_comb begin
        n10_sn    = r9_sn;
        n10_sd    = r9_sd;
        n10_tn    = r9_tn;
        n10_x     = -r9_ds;
        n10_clamp = 1'b0;
        if (r9_tn < 0) begin
            n10_tn    = '0;
            n10_x     = -r9_ds;
            n10_clamp = 1'b1;
        end else if (r9_tn > r9_td) begin
            n10_tn    = r9_td;
            n10_x     = r9_bs - r9_ds;
            n10_clamp = 1'b1;
        end
        if (n10_clamp) begin
            if (n10_x < 0) begin
                n10_sn = '0;
            end else if (n10_x > r9_as) begin
                n10_sn = r9_sd;
            end else begin
                n10_sn = n10_x;
                n10_sd = r9_as;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r10_sn <= n10_sn;
        r10_sd <= n10_sd;
        r10_tn <= n10_tn;
        r10_td <= r9_td;
        r10_u  <= r9_u;
        r10_v  <= r9_v;
        r10_w  <= r9_w;
    end

    // ------------------------------------------------------------------
    // Parameter division: small numerators or a non-positive numerator or denominator give zero
    // ------------------------------------------------------------------
    logic signed [QW-1:0] abs_sn, abs_tn;
    ssd_pkg::t_div_ctl    ctl_s, ctl_t;
    logic                 s_vld;
    logic [SCW-1:0]       s_sc, s_tc;

    assign abs_sn = (r10_sn < 0) ? -r10_sn : r10_sn;
    assign abs_tn = (r10_tn < 0) ? -r10_tn : r10_tn;

    always_comb begin
        ctl_s.vld  = r10_vld;
        ctl_s.zero = (abs_sn < eps_q) || (r10_sn <= 0) || (r10_sd <= 0);
        ctl_s.full = (r10_sn >= r10_sd);
        ctl_t.vld  = r10_vld;
        ctl_t.zero = (abs_tn < eps_q) || (r10_tn <= 0) || (r10_td <= 0);
        ctl_t.full = (r10_tn >= r10_td);
    end

    ssd_div u_div_s (.i_clk, .i_rst_n, .i_ctl(ctl_s), .i_num(r10_sn), .i_den(r10_sd),
                     .o_vld(s_vld), .o_quo(s_sc));
    ssd_div u_div_t (.i_clk, .i_rst_n, .i_ctl(ctl_t), .i_num(r10_tn), .i_den(r10_td),
                     .o_vld(), .o_quo(s_tc));

    logic signed [DW-1:0] r11_u [DIV_LAT][3], r11_v [DIV_LAT][3], r11_w [DIV_LAT][3];

    always_ff @(posedge i_clk) begin
        r11_u[0] <= r10_u;
        r11_v[0] <= r10_v;
        r11_w[0] <= r10_w;
        for (int i = 1; i < DIV_LAT; i++) begin
            r11_u[i] <= r11_u[i-1];
            r11_v[i] <= r11_v[i-1];
            r11_w[i] <= r11_w[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Closest vector: w + s*u - t*v at Q.(FRAC_BITS+PB)
    // ------------------------------------------------------------------
    logic                 rp_vld;
    logic signed [PW:0]   rp_su [3], rp_tv [3];
    logic signed [DW-1:0] rp_w [3];
    logic signed [SCW:0]  sc_s, tc_s;

    logic                 rc_vld;
    logic signed [MW-1:0] rc_cmp [3];
    logic signed [MW-1:0] ext_w [3];

    assign sc_s = {1'b0, s_sc};
    assign tc_s = {1'b0, s_tc};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ext_w[k] = rp_w[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            rp_su[k]  <= sc_s * r11_u[DIV_LAT-1][k];
            rp_tv[k]  <= tc_s * r11_v[DIV_LAT-1][k];
            rp_w[k]   <= r11_w[DIV_LAT-1][k];
            rc_cmp[k] <= (ext_w[k] <<< PB) + rp_su[k] - rp_tv[k];
        end
    end

    // ------------------------------------------------------------------
    // Squared length
    // ------------------------------------------------------------------
    logic                  q_vld;
    logic signed [MPW-1:0] q_sq [3];

    ssd_mul u_mul_sq0 (.i_clk, .i_rst_n, .i_vld(rc_vld), .i_a(rc_cmp[0]), .i_b(rc_cmp[0]),
                       .o_vld(q_vld), .o_p(q_sq[0]));
    ssd_mul u_mul_sq1 (.i_clk, .i_rst_n, .i_vld(rc_vld), .i_a(rc_cmp[1]), .i_b(rc_cmp[1]),
                       .o_vld(), .o_p(q_sq[1]));
    ssd_mul u_mul_sq2 (.i_clk, .i_rst_n, .i_vld(rc_vld), .i_a(rc_cmp[2]), .i_b(rc_cmp[2]),
                       .o_vld(), .o_p(q_sq[2]));

    // ------------------------------------------------------------------
    // Square root: one result bit per stage
    // ------------------------------------------------------------------
    logic           r_sq_vld [SQS+1];
    logic [SQW-1:0] r_sq_num [SQS+1];
    logic [SQW-1:0] r_sq_res [SQS+1];
    logic [SQW-1:0] sq_trial [SQS];
    logic           sq_take  [SQS];

    always_comb begin
        for (int k = 0; k < SQS; k++) begin
            sq_trial[k] = r_sq_res[k] + (SQW'(1) << (2 * (SQS - 1 - k)));
            sq_take[k]  = (r_sq_num[k] >= sq_trial[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_num[0] <= SQW'(q_sq[0]) + SQW'(q_sq[1]) + SQW'(q_sq[2]);
        r_sq_res[0] <= '0;
        for (int k = 0; k < SQS; k++) begin
            if (sq_take[k]) begin
                r_sq_num[k+1] <= r_sq_num[k] - sq_trial[k];
                r_sq_res[k+1] <= (r_sq_res[k] >> 1) + (SQW'(1) << (2 * (SQS - 1 - k)));
            end else begin
                r_sq_num[k+1] <= r_sq_num[k];
                r_sq_res[k+1] <= r_sq_res[k] >> 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Round to FRAC_BITS, saturate, drive the result
    // ------------------------------------------------------------------
    logic [SQW-1:0]   rnd_len;
    logic [DISTW-1:0] r_dist;
    logic             r_done;

    assign rnd_len = (r_sq_res[SQS] + HALF) >> PB;

    always_ff @(posedge i_clk) begin
        r_dist <= (rnd_len > DMAX) ? DMAX[DISTW-1:0] : rnd_len[DISTW-1:0];
    end

    // Advance valid bits through the later stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            rp_vld  <= 1'b0;
            rc_vld  <= 1'b0;
            for (int k = 0; k <= SQS; k++) begin
                r_sq_vld[k] <= 1'b0;
            end
            r_done  <= 1'b0;
        end else begin
            r8_vld  <= m_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
            rp_vld  <= s_vld;
            rc_vld  <= rp_vld;
            r_sq_vld[0] <= q_vld;
            for (int k = 0; k < SQS; k++) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
            r_done  <= r_sq_vld[SQS];
        end
    end

    assign o_done     = r_done;
    assign o_distance = r_dist;

endmodule

[rtl/ssd_mul.sv]
// ----------------------------------------------------------------------------
// ssd_mul: pipelined wide signed multiplier
// Sign-magnitude split, four limb partial products, limb sum, sign restore.
// One product per clock; each of these steps is registered.
// ----------------------------------------------------------------------------
module ssd_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  logic signed [ssd_pkg::MW-1:0]  i_a,
    input  logic signed [ssd_pkg::MW-1:0]  i_b,
    output logic                           o_vld,
    output logic signed [ssd_pkg::MPW-1:0] o_p
);
    localparam int MW  = ssd_pkg::MW;
    localparam int LW  = ssd_pkg::LW;
    localparam int MPW = ssd_pkg::MPW;

    logic [ssd_pkg::MUL_LAT-1:0] r_vld;

    logic          r1_sgn;
    logic [MW-1:0] r1_ma;
    logic [MW-1:0] r1_mb;

    logic            r2_sgn;
    logic [2*LW-1:0] r2_ll;
    logic [2*LW-1:0] r2_lh;
    logic [2*LW-1:0] r2_hl;
    logic [2*LW-1:0] r2_hh;

    logic           r3_sgn;
    logic [MPW-1:0] r3_mag;

    logic signed [MPW-1:0] r4_p;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ssd_pkg::MUL_LAT-2:0], i_vld};
        end
    end

    // Split into sign and magnitude, multiply limbs, sum, restore sign
    always_ff @(posedge i_clk) begin
        r1_sgn <= i_a[MW-1] ^ i_b[MW-1];
        r1_ma  <= i_a[MW-1] ? MW'(-i_a) : MW'(i_a);
        r1_mb  <= i_b[MW-1] ? MW'(-i_b) : MW'(i_b);

        r2_sgn <= r1_sgn;
        r2_ll  <= r1_ma[LW-1:0]  * r1_mb[LW-1:0];
        r2_lh  <= r1_ma[LW-1:0]  * r1_mb[MW-1:LW];
        r2_hl  <= r1_ma[MW-1:LW] * r1_mb[LW-1:0];
        r2_hh  <= r1_ma[MW-1:LW] * r1_mb[MW-1:LW];

        r3_sgn <= r2_sgn;
        r3_mag <= {r2_hh, r2_ll} + (MPW'(r2_lh) << LW) + (MPW'(r2_hl) << LW);

        r4_p   <= r3_sgn ? -$signed(r3_mag) : $signed(r3_mag);
    end

    assign o_vld = r_vld[ssd_pkg::MUL_LAT-1];
    assign o_p   = r4_p;

endmodule

[rtl/ssd_div.sv]
// ----------------------------------------------------------------------------
// ssd_div: pipelined restoring divider for segment parameters
// Takes a positive numerator below a positive denominator and returns the
// quotient as unsigned Q1.32, rounded half up. One quotient bit per stage.
// ----------------------------------------------------------------------------
module ssd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ssd_pkg::t_div_ctl          i_ctl,
    input  logic [ssd_pkg::QW-1:0]     i_num,
    input  logic [ssd_pkg::QW-1:0]     i_den,
    output logic                       o_vld,
    output logic [ssd_pkg::SCW-1:0]    o_quo
);
    localparam int QW = ssd_pkg::QW;
    localparam int PB = ssd_pkg::PB;

    ssd_pkg::t_div_ctl r_ctl [PB+1];
    logic [QW-1:0]     r_rem [PB+1];
    logic [QW-1:0]     r_den [PB+1];
    logic [PB-1:0]     r_quo [PB+1];

    logic [QW-1:0] sh  [PB+1];
    logic          ge  [PB+1];

    logic                   r_vld_out;
    logic [ssd_pkg::SCW-1:0] r_quo_out;

    // Trial subtract at every stage, plus the rounding compare at the end
    always_comb begin
        for (int k = 0; k <= PB; k++) begin
            sh[k] = {r_rem[k][QW-2:0], 1'b0};
            ge[k] = (sh[k] >= r_den[k]);
        end
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= PB; k++) begin
                r_ctl[k] <= '0;
            end
            r_vld_out <= 1'b0;
        end else begin
            r_ctl[0] <= i_ctl;
            for (int k = 0; k < PB; k++) begin
                r_ctl[k+1] <= r_ctl[k];
            end
            r_vld_out <= r_ctl[PB].vld;
        end
    end

    // Shift in one quotient bit per stage
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        for (int k = 0; k < PB; k++) begin
            r_rem[k+1] <= ge[k] ? sh[k] - r_den[k] : sh[k];
            r_den[k+1] <= r_den[k];
            r_quo[k+1] <= {r_quo[k][PB-2:0], ge[k]};
        end
        if (r_ctl[PB].zero) begin
            r_quo_out <= '0;
        end else if (r_ctl[PB].full) begin
            r_quo_out <= ssd_pkg::SCW'(1) << PB;
        end else begin
            r_quo_out <= {1'b0, r_quo[PB]} + ssd_pkg::SCW'(ge[PB]);
        end
    end

    assign o_vld = r_vld_out;
    assign o_quo = r_quo_out;

endmodule

[rtl/ssd_chk.sv]
// ----------------------------------------------------------------------------
// ssd_chk: port-level checker for the 3D segment distance block
// Watches accepts against result strobes and a known-zero distance case.
// ----------------------------------------------------------------------------
module ssd_chk (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic signed [ssd_pkg::COORD_WIDTH-1:0] i_first_start_x,
    input logic signed [ssd_pkg::COORD_WIDTH-1:0] i_first_start_y,
    input logic signed [ssd_pkg::COORD_WIDTH-1:0] i_first_start_z,
    input logic signed [ssd_pkg::COORD_WIDTH-1:0] i_first_end_x,
    input logic signed [ssd_pkg::COORD_WIDTH-1:0] i_first_end_y,
    input logic signed [ssd_pkg::COORD_WIDTH-1:0] i_first_end_z,
    input logic signed [ssd_pkg::COORD_WIDTH-1:0] i_second_start_x,
    input logic signed [ssd_pkg::COORD_WIDTH-1:0] i_second_start_y,
    input logic signed [ssd_pkg::COORD_WIDTH-1:0] i_second_start_z,
    input logic signed [ssd_pkg::COORD_WIDTH-1:0] i_second_end_x,
    input logic signed [ssd_pkg::COORD_WIDTH-1:0] i_second_end_y,
    input logic signed [ssd_pkg::COORD_WIDTH-1:0] i_second_end_z,
    input logic                                   o_done,
    input logic [ssd_pkg::DISTW-1:0]              o_distance
);
    logic accept;
    logic same_seg;

    assign accept   = start && !busy;
    assign same_seg = (i_first_start_x == i_second_start_x) &&
                      (i_first_start_y == i_second_start_y) &&
                      (i_first_start_z == i_second_start_z) &&
                      (i_first_end_x == i_second_end_x) &&
                      (i_first_end_y == i_second_end_y) &&
                      (i_first_end_z == i_second_end_z);

    // The block never pushes back
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // Every accepted item yields a result after the fixed latency
    a_item_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(ssd_pkg::LAT) o_done)
        else $error("result missing after accept");

    // No result without an accepted item
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, ssd_pkg::LAT))
        else $error("result without matching accept");

    // A segment against itself is at distance zero
    a_self_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && same_seg) |-> ##(ssd_pkg::LAT) (o_done && (o_distance == '0)))
        else $error("nonzero distance for identical segments");

endmodule

bind segment_segment_distance_3d ssd_chk u_ssd_chk (.*);

[tb/segment_segment_distance_3d_tb.sv]
// ----------------------------------------------------------------------------
// segment_segment_distance_3d_tb: self-checking bench for the segment distance
// Drives segment pairs through the command port with random sender gaps,
// predicts each distance with exact wide-integer arithmetic and compares
// every o_done strobe with the oldest predicted distance.
// ----------------------------------------------------------------------------
module segment_segment_distance_3d_tb;

    localparam int COORD_WIDTH = ssd_pkg::COORD_WIDTH;
    localparam int FRAC_BITS   = ssd_pkg::FRAC_BITS;
    localparam int EW          = ssd_pkg::EW;
    localparam int PB          = ssd_pkg::PB;
    localparam int SCW         = ssd_pkg::SCW;
    localparam int DISTW       = ssd_pkg::DISTW;
    localparam int LAT         = ssd_pkg::LAT;
    localparam logic [EW-1:0] EPS_RESET = ssd_pkg::EPS_RESET;

    typedef logic signed [255:0] t_wide;
    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    localparam logic [EW-1:0] EPS_MAX = {EW{1'b1}};
    localparam int DRAIN = LAT + 8;

    // Item coordinate order: first start, first end, second start, second end
    localparam int N_COORD = 12;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_coord               coord [N_COORD];
    logic                 i_cfg_we;
    logic [EW-1:0]        i_cfg_wdata;
    logic                 o_done;
    logic [DISTW-1:0]     o_distance;

    logic [EW-1:0]        eps_model;
    logic [DISTW-1:0]     distance_q [$];
    int                   mismatches;
    int                   send_idle_pct;

    segment_segment_distance_3d uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_first_start_x (coord[0]),
        .i_first_start_y (coord[1]),
        .i_first_start_z (coord[2]),
        .i_first_end_x   (coord[3]),
        .i_first_end_y   (coord[4]),
        .i_first_end_z   (coord[5]),
        .i_second_start_x(coord[6]),
        .i_second_start_y(coord[7]),
        .i_second_start_z(coord[8]),
        .i_second_end_x  (coord[9]),
        .i_second_end_y  (coord[10]),
        .i_second_end_z  (coord[11]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_distance      (o_distance)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Rounded quotient n/d as unsigned Q1.32; zero unless both are positive, 1.0 if n >= d
    function automatic logic [SCW-1:0] param_ratio(t_wide n, t_wide d);
        logic [SCW-1:0] q;
        t_wide r;
        q = '0;
        r = n;
        if (n <= 0 || d <= 0) return '0;
        if (n >= d) return SCW'(1) << PB;
        for (int k = 0; k < PB; k++) begin
            r = r <<< 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        r = r <<< 1;
        if (r >= d) q = q + 1;
        return q;
    endfunction

    // Floor of the square root of a non-negative value below 2^256
    function automatic logic [255:0] floor_sqrt(logic [255:0] s);
        logic [255:0] r;
        logic [255:0] cand;
        r = '0;
        for (int b = 127; b >= 0; b--) begin
            cand = r | (256'd1 << b);
            if (cand * cand <= s) r = cand;
        end
        return r;
    endfunction

    // Predict the closest distance for one segment pair
    function automatic logic [DISTW-1:0] segment_distance(t_coord c [N_COORD],
                                                         logic [EW-1:0] eps_val);
        t_wide u [3];
        t_wide v [3];
        t_wide w [3];
        t_wide p0, p1, q0, q1;
        t_wide a, b, cc, d, e, as, bs, cs, ds, es, den, epsw, one, x;
        t_wide sn, sd, tn, td, comp, sum;
        logic [SCW-1:0] sc, tc;
        logic [255:0] root;
        for (int k = 0; k < 3; k++) begin
            p0 = c[k];
            p1 = c[3 + k];
            q0 = c[6 + k];
            q1 = c[9 + k];
            u[k] = p1 - p0;
            v[k] = q1 - q0;
            w[k] = p0 - q0;
        end
        a = 0; b = 0; cc = 0; d = 0; e = 0;
        for (int k = 0; k < 3; k++) begin
            a  = a  + u[k] * u[k];
            b  = b  + u[k] * v[k];
            cc = cc + v[k] * v[k];
            d  = d  + u[k] * w[k];
            e  = e  + v[k] * w[k];
        end
        as = a <<< (2 * FRAC_BITS);
        bs = b <<< (2 * FRAC_BITS);
        cs = cc <<< (2 * FRAC_BITS);
        ds = d <<< (2 * FRAC_BITS);
        es = e <<< (2 * FRAC_BITS);
        den = a * cc - b * b;
        epsw = 0;
        epsw[EW-1:0] = eps_val;
        one = t_wide'(1) <<< (4 * FRAC_BITS);

        // Parallel pairs pin s to zero; otherwise clamp s to 0..den
        if (den < epsw) begin
            sn = 0; sd = one; tn = es; td = cs;
        end else begin
            sn = b * e - cc * d;
            tn = a * e - b * d;
            sd = den;
            td = den;
            if (sn < 0) begin
                sn = 0; tn = es; td = cs;
            end else if (sn > sd) begin
                sn = sd; tn = es + bs; td = cs;
            end
        end

        // Clamp t and recompute s where t hits an end
        if (tn < 0) begin
            tn = 0;
            x = -ds;
            if (x < 0) sn = 0;
            else if (x > as) sn = sd;
            else begin
                sn = x; sd = as;
            end
        end else if (tn > td) begin
            tn = td;
            x = bs - ds;
            if (x < 0) sn = 0;
            else if (x > as) sn = sd;
            else begin
                sn = x; sd = as;
            end
        end

        // Small numerators give a zero parameter
        x = (sn < 0) ? -sn : sn;
        sc = (x < epsw) ? '0 : param_ratio(sn, sd);
        x = (tn < 0) ? -tn : tn;
        tc = (x < epsw) ? '0 : param_ratio(tn, td);

        sum = 0;
        for (int k = 0; k < 3; k++) begin
            comp = (w[k] <<< PB) + t_wide'({1'b0, sc}) * u[k]
                   - t_wide'({1'b0, tc}) * v[k];
            sum = sum + comp * comp;
        end
        root = floor_sqrt(sum);
        root = (root + (256'd1 << (PB - 1))) >> PB;
        if (root > {{(256 - DISTW){1'b0}}, {DISTW{1'b1}}}) return {DISTW{1'b1}};
        return root[DISTW-1:0];
    endfunction

    // Random coordinate: full range, small, or an extreme
    function automatic t_coord rand_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return t_coord'($urandom);
        if (pick < 8) return t_coord'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
        if (pick == 8) return {1'b1, {(COORD_WIDTH - 1){1'b0}}};
        return {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    endfunction

    // Send one item; the caller stands on a rising edge
    task automatic send_pair(t_coord c [N_COORD]);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        for (int k = 0; k < N_COORD; k++) coord[k] <= c[k];
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        distance_q.push_back(segment_distance(c, eps_model));
        @(posedge i_clk);
    endtask

    // Drop start, let the pipeline drain, then write epsilon
    task automatic write_epsilon(logic [EW-1:0] val);
        start <= 1'b0;
        while (distance_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        eps_model   = val;
    endtask

    // Directed pairs: extremes, crossing, parallel, degenerate points
    task automatic test_directed();
        t_coord c [N_COORD];
        t_coord mx, mn;
        mx = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
        mn = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
        // all zero: both segments are one point
        foreach (c[k]) c[k] = '0;
        send_pair(c);
        // crossing at the origin
        c = '{-65536, 0, 0, 65536, 0, 0, 0, -65536, 0, 0, 65536, 0};
        send_pair(c);
        // skew lines one unit apart
        c = '{-65536, 0, 0, 65536, 0, 0, 0, -65536, 65536, 0, 65536, 65536};
        send_pair(c);
        // parallel, offset
        c = '{0, 0, 0, 131072, 0, 0, 65536, 65536, 0, 196608, 65536, 0};
        send_pair(c);
        // collinear, disjoint
        c = '{0, 0, 0, 65536, 0, 0, 196608, 0, 0, 262144, 0, 0};
        send_pair(c);
        // closest points past both ends
        c = '{0, 0, 0, 65536, 65536, 0, 327680, 0, 65536, 393216, -65536, 65536};
        send_pair(c);
        // extreme corners
        c = '{mn, mn, mn, mx, mx, mx, mx, mn, mx, mn, mx, mn};
        send_pair(c);
        c = '{mn, mn, mn, mn, mn, mn, mx, mx, mx, mx, mx, mx};
        send_pair(c);
        c = '{mx, mn, mx, mx, mn, mx, mn, mx, mn, mx, mn, mx};
        send_pair(c);
        // one degenerate segment
        c = '{5, 7, -9, 5, 7, -9, 0, 0, 0, 100000, -200000, 300000};
        send_pair(c);
        // tiny segments, near-zero numerators
        c = '{0, 0, 0, 1, 0, 0, 2, 1, 0, 2, 2, 0};
        send_pair(c);
    endtask

    // Degenerate, parallel, skew and other pairs under the extreme thresholds
    task automatic test_epsilon_extremes();
        t_coord c [N_COORD];
        write_epsilon('0);
        foreach (c[k]) c[k] = '0;
        send_pair(c);
        c = '{3, 4, 5, 3, 4, 5, -7, 8, 1, -7, 8, 1};
        send_pair(c);
        c = '{0, 0, 0, 65536, 0, 0, 65536, 65536, 0, 196608, 65536, 0};
        send_pair(c);
        c = '{-65536, 0, 0, 65536, 0, 0, 0, -65536, 65536, 0, 65536, 65536};
        send_pair(c);
        write_epsilon(EPS_MAX);
        send_pair(c);
        c = '{0, 0, 0, 1, 0, 0, 2, 1, 0, 2, 2, 0};
        send_pair(c);
        c = '{-100, 50, 0, 100, -50, 10, 7, 7, 7, -7, -7, -7};
        send_pair(c);
    endtask

    // Random pairs in a mix of shapes
    task automatic test_random(int count);
        t_coord c [N_COORD];
        int shape, sc, off;
        for (int n = 0; n < count; n++) begin
            foreach (c[k]) c[k] = rand_coord();
            shape = $urandom_range(0, 5);
            sc = $urandom_range(1, 4);
            off = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 0;
            for (int k = 0; k < 3; k++) begin
                case (shape)
                    // parallel, or nearly when off is set: second direction is sc times the first
                    1: c[9 + k] = c[6 + k] + sc * (c[3 + k] - c[k]) + off;
                    // degenerate second segment
                    2: c[9 + k] = c[6 + k];
                    // degenerate first segment
                    3: c[3 + k] = c[k];
                    // nearly overlapping pair
                    4: begin
                        c[6 + k] = c[k] + off;
                        c[9 + k] = c[3 + k] - off;
                    end
                    default: ;
                endcase
            end
            send_pair(c);
        end
    endtask

    // Compare each strobed distance with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (distance_q.size() == 0) begin
                $error("distance: expected none, got %0d", o_distance);
                mismatches++;
            end else begin
                logic [DISTW-1:0] want;
                want = distance_q.pop_front();
                if (o_distance !== want) begin
                    $error("distance: expected %0d, got %0d", want, o_distance);
                    mismatches++;
                end
            end
        end
    end

    // Run limit
    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

    // Sequence
    initial begin
        mismatches    = 0;
        send_idle_pct = 17;
        eps_model     = EPS_RESET;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        foreach (coord[k]) coord[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_epsilon_extremes();

        write_epsilon(EPS_RESET);
        test_random(150);
        send_idle_pct = 80;
        write_epsilon(EW'({$urandom, $urandom}));
        test_random(75);
        write_epsilon('0);
        test_random(75);
        send_idle_pct = 0;
        write_epsilon(EW'({$urandom_range(0, 255), $urandom}));
        test_random(100);
        write_epsilon(EPS_MAX);
        test_random(50);

        start <= 1'b0;
        while (distance_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ssd_pkg.sv
rtl/ssd_mul.sv
rtl/ssd_div.sv
rtl/segment_segment_distance_3d.sv
rtl/ssd_chk.sv
tb/segment_segment_distance_3d_tb.sv
